/* rtl/double_ended_queue_with_search_macros.svh */
// Assertion macros used by the deque top level.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define DQS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must never hold.
`define DQS_ASSERT_NEVER(label, bad, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(bad)) \
      else $error(msg);

`endif

/* rtl/dqs_pkg.sv */
// Package with types, sizes and codes of the double-ended queue.
`timescale 1ns / 1ps
package dqs_pkg;

   localparam int DEPTH        = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int PORT_W       = 32;
   localparam int WORD_W       = (DATA_WIDTH < PORT_W) ? DATA_WIDTH : PORT_W;
   localparam int COUNT_W      = $clog2(DEPTH + 1);
   localparam int COUNT_PORT_W = 5;
   localparam int OP_W         = 3;
   localparam int STATUS_W     = 2;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_PUSH_TAIL = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_PEEK_HEAD = 3'd4,
      OP_PEEK_TAIL = 3'd5,
      OP_SEARCH    = 3'd6,
      OP_COUNT     = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic      push_head;
      logic      pop_head;
      logic      push_tail;
      count_type count;
   } cell_ctrl_type;

endpackage

/* rtl/dqs_cell.sv */
// One storage cell of the deque chain: holds a word, shifts with its neighbors.
`timescale 1ns / 1ps
module dqs_cell (
   input  logic                   clock,
   input  dqs_pkg::count_type     cell_index,
   input  dqs_pkg::cell_ctrl_type ctrl,
   input  dqs_pkg::word_type      push_word,
   input  dqs_pkg::word_type      key_word,
   input  dqs_pkg::word_type      left_word,
   input  dqs_pkg::word_type      right_word,
   output dqs_pkg::word_type      word_out,
   output dqs_pkg::word_type      tail_word,
   output logic                   hit
);
   import dqs_pkg::*;

   word_type word_ff;
   word_type word_in;
   logic     held;
   logic     is_tail;
   logic     is_slot;

   assign held    = cell_index < ctrl.count;
   assign is_slot = cell_index == ctrl.count;
   assign is_tail = (cell_index + 1'b1) == ctrl.count;

   always_comb begin
      word_in = word_ff;
      if (ctrl.push_head) begin
         word_in = left_word;
      end else if (ctrl.pop_head) begin
         word_in = right_word;
      end else if (ctrl.push_tail && is_slot) begin
         word_in = push_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out  = word_ff;
   assign tail_word = is_tail ? word_ff : '0;
   assign hit       = held && (word_ff == key_word);

endmodule

/* rtl/double_ended_queue_with_search.sv */
// Top level of the double-ended queue with key search.
`timescale 1ns / 1ps
// Bounded deque of DEPTH words held in a chain of cells, head in cell 0. Pushing at
// the head shifts the whole chain one cell toward the tail, popping the head shifts
// it back; tail operations write or read the cell selected by the entry count. A
// search compares the key in every held cell at once. Every item yields one result with
// the word, found flag, count after the operation and status (ok, empty, full).
// The block takes one item per cycle: each operation completes in the single cell
// update, and the result register holds a taken item while rsp_stall is high, which
// stalls the request side until that result leaves. Each result is registered.
`include "double_ended_queue_with_search_macros.svh"
module double_ended_queue_with_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dqs_pkg::OP_W-1:0]            req_operation,
   input  logic [dqs_pkg::PORT_W-1:0]          req_push_value,
   input  logic [dqs_pkg::PORT_W-1:0]          req_search_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dqs_pkg::PORT_W-1:0]          rsp_result_value,
   output logic                                rsp_found,
   output logic [dqs_pkg::COUNT_PORT_W-1:0]    rsp_entry_count,
   output logic [dqs_pkg::STATUS_W-1:0]        rsp_status
);
   import dqs_pkg::*;

   logic          accept;
   op_type        op;
   logic          full;
   logic          empty;
   word_type      push_word;
   word_type      key_word;
   cell_ctrl_type ctrl;

   count_type     count_ff;
   count_type     count_in;

   word_type      chain_word [DEPTH];
   word_type      left_word  [DEPTH];
   word_type      right_word [DEPTH];
   word_type      tail_word  [DEPTH];
   logic          hit        [DEPTH];
   word_type      tail_any;
   logic          hit_any;

   logic [PORT_W-1:0] result_in;
   logic              found_in;
   status_type        status_in;

   logic              rsp_valid_ff;
   logic [PORT_W-1:0] result_ff;
   logic              found_ff;
   count_type         rsp_count_ff;
   status_type        status_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_operation);
   assign full      = count_ff == count_type'(DEPTH);
   assign empty     = count_ff == '0;
   assign push_word = WORD_W'(req_push_value);
   assign key_word  = WORD_W'(req_search_key);

   // Decode the operation into cell commands and the result fields.
   always_comb begin
      ctrl           = '0;
      ctrl.count     = count_ff;
      count_in       = count_ff;
      result_in      = '0;
      found_in       = 1'b0;
      status_in      = ST_OK;
      case (op)
         OP_PUSH_HEAD: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.push_head = accept;
               count_in       = count_ff + 1'b1;
            end
         end
         OP_PUSH_TAIL: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.push_tail = accept;
               count_in       = count_ff + 1'b1;
            end
         end
         OP_POP_HEAD: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               ctrl.pop_head = accept;
               result_in     = PORT_W'(chain_word[0]);
               count_in      = count_ff - 1'b1;
            end
         end
         OP_POP_TAIL: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               result_in = PORT_W'(tail_any);
               count_in  = count_ff - 1'b1;
            end
         end
         OP_PEEK_HEAD: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               result_in = PORT_W'(chain_word[0]);
            end
         end
         OP_PEEK_TAIL: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               result_in = PORT_W'(tail_any);
            end
         end
         OP_SEARCH: begin
            found_in = hit_any;
         end
         OP_COUNT: begin
            count_in = count_ff;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_word[i] = push_word;
      end else begin : g_inner_left
         assign left_word[i] = chain_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word[i] = chain_word[i];
      end else begin : g_inner_right
         assign right_word[i] = chain_word[i+1];
      end

      dqs_cell u_cell (
         .clock      (clock),
         .cell_index (count_type'(i)),
         .ctrl       (ctrl),
         .push_word  (push_word),
         .key_word   (key_word),
         .left_word  (left_word[i]),
         .right_word (right_word[i]),
         .word_out   (chain_word[i]),
         .tail_word  (tail_word[i]),
         .hit        (hit[i])
      );
   end

   // Only the tail cell drives a nonzero tail word, so OR picks it out; hits are ORed.
   always_comb begin
      tail_any = '0;
      hit_any  = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_any = tail_any | tail_word[i];
         hit_any  = hit_any | hit[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff    <= result_in;
         found_ff     <= found_in;
         rsp_count_ff <= count_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = result_ff;
   assign rsp_found        = found_ff;
   assign rsp_entry_count  = COUNT_PORT_W'(rsp_count_ff);
   assign rsp_status       = status_ff;

   `DQS_ASSERT_NEVER(a_count_bound, count_ff > count_type'(DEPTH), "count above depth")
   `DQS_ASSERT_NEXT(a_full_refused, accept && full && (op == OP_PUSH_HEAD || op == OP_PUSH_TAIL), status_ff == ST_FULL && $stable(count_ff), "push on full queue not refused")
   `DQS_ASSERT_NOW(a_empty_result, rsp_valid_ff && status_ff == ST_EMPTY, result_ff == '0 && rsp_count_ff == '0, "empty status with data or count")
   `DQS_ASSERT_NEXT(a_found_search, accept && op != OP_SEARCH, !found_ff, "found set outside search")
   `DQS_ASSERT_NEXT(a_count_tracks, accept, rsp_count_ff == count_ff, "reported count differs from held count")

endmodule
